@@ design/ngea_pkg.sv @@
package ngea_pkg;

    // field and register widths fixed by the interface
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int PHASE_W  = 2;

    localparam int MAX_CLIENTS_DEF = 8;
    localparam logic [CNT_W-1:0] CLIENT_COUNT_RST = 4'd5;

    // register index taken from paddr[2]
    localparam logic REG_CLIENT_COUNT = 1'b0;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        THINKING = 2'd0,
        HUNGRY   = 2'd1,
        EATING   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ,
        ST_LEFT,
        ST_RIGHT,
        ST_BAD
    } state_t;

    // which pair of phases the ram fetches for the next cycle
    typedef enum logic [1:0] {
        RD_REQ,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    // which grant test the datapath evaluates
    typedef enum logic [1:0] {
        EV_REQ,
        EV_LEFT,
        EV_RIGHT
    } eval_sel_t;

    typedef struct packed {
        logic      load;
        logic      mark;
        phase_t    mark_phase;
        rd_sel_t   rd_sel;
        eval_sel_t eval_sel;
        logic      emit;
        logic      emit_bad;
        logic      emit_last;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic out_free;
    } sts_t;

endpackage

@@ design/ngea_ram.sv @@
module ngea_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // registered read, old data on a clash with the write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/ngea_ctrl.sv @@
module ngea_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          func,
    output logic          in_stall,
    input  ngea_pkg::sts_t sts,
    output ngea_pkg::cmd_t cmd
);

    import ngea_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.mark       = 1'b0;
        cmd.mark_phase = THINKING;
        cmd.eval_sel   = EV_REQ;
        cmd.emit       = 1'b0;
        cmd.emit_bad   = 1'b0;
        cmd.emit_last  = 1'b0;
        in_stall       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (sts.in_bad)
                    begin
                        state_next = ST_BAD;
                    end
                    else if (func == FUNC_RELEASE)
                    begin
                        cmd.mark       = 1'b1;
                        cmd.mark_phase = THINKING;
                        state_next     = ST_LEFT;
                    end
                    else
                    begin
                        cmd.mark       = 1'b1;
                        cmd.mark_phase = HUNGRY;
                        state_next     = ST_REQ;
                    end
                end
            end
            ST_REQ:
            begin
                cmd.eval_sel = EV_REQ;
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LEFT:
            begin
                cmd.eval_sel = EV_LEFT;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RIGHT;
                end
            end
            ST_RIGHT:
            begin
                cmd.eval_sel = EV_RIGHT;
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_BAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_bad  = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // fetch what the next state tests, again while waiting
        unique case (state_next)
            ST_LEFT:  cmd.rd_sel = RD_LEFT;
            ST_RIGHT: cmd.rd_sel = RD_RIGHT;
            default:  cmd.rd_sel = RD_REQ;
        endcase
    end

endmodule

@@ design/ngea_dp.sv @@
module ngea_dp #(
    parameter int MAX_CLIENTS = ngea_pkg::MAX_CLIENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ngea_pkg::ADDR_W-1:0]   paddr,
    input  logic [ngea_pkg::DATA_W-1:0]   pwdata,
    output logic [ngea_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic [ngea_pkg::IDX_W-1:0]    client_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ngea_pkg::IDX_W-1:0]    tested_client,
    output logic                          granted,
    output logic                          bad_index,
    output logic                          last_result,
    input  ngea_pkg::cmd_t                cmd,
    output ngea_pkg::sts_t                sts
);

    import ngea_pkg::*;

    localparam int IW = $clog2(MAX_CLIENTS);
    localparam int NW = $clog2(MAX_CLIENTS + 1);
    localparam int SW = (NW > CNT_W) ? NW : CNT_W;
    localparam int BW = (NW > IDX_W) ? NW : IDX_W;

    function automatic logic [IW-1:0] ring_left(input logic [IW-1:0] x,
                                                input logic [NW-1:0] n);
        logic [NW-1:0] nm1;
        nm1 = n - NW'(1);
        if (x == '0)
            ring_left = IW'(nm1);
        else
            ring_left = x - IW'(1);
    endfunction

    function automatic logic [IW-1:0] ring_right(input logic [IW-1:0] x,
                                                 input logic [NW-1:0] n);
        logic [NW-1:0] nm1;
        nm1 = n - NW'(1);
        if (NW'(x) == nm1)
            ring_right = '0;
        else
            ring_right = x + IW'(1);
    endfunction

    // configuration
    logic [CNT_W-1:0] client_count_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CLIENT_COUNT);
    assign prdata = (paddr[2] == REG_CLIENT_COUNT) ? DATA_W'(client_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_count_reg <= CLIENT_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            client_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // ring size clamped into 2..MAX_CLIENTS
    logic [SW-1:0] cnt_w;
    logic [SW-1:0] ring_w;
    logic [NW-1:0] ring_n;

    always_comb
    begin
        cnt_w = SW'(client_count_reg);
        priority if (cnt_w < SW'(2))
            ring_w = SW'(2);
        else if (cnt_w > SW'(MAX_CLIENTS))
            ring_w = SW'(MAX_CLIENTS);
        else
            ring_w = cnt_w;
    end

    assign ring_n = NW'(ring_w);

    // item registers
    logic [IW-1:0]    cidx_reg;
    logic [IDX_W-1:0] idx_raw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cidx_reg    <= IW'(client_index);
            idx_raw_reg <= client_index;
        end
    end

    // ring neighbours around the current client
    logic [IW-1:0] base;
    logic [IW-1:0] nb_l;
    logic [IW-1:0] nb_r;
    logic [IW-1:0] nb_ll;
    logic [IW-1:0] nb_rr;

    assign base  = cmd.load ? IW'(client_index) : cidx_reg;
    assign nb_l  = ring_left(base, ring_n);
    assign nb_r  = ring_right(base, ring_n);
    assign nb_ll = ring_left(nb_l, ring_n);
    assign nb_rr = ring_right(nb_r, ring_n);

    logic [IW-1:0] rd_a;
    logic [IW-1:0] rd_b;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_REQ:
            begin
                rd_a = nb_l;
                rd_b = nb_r;
            end
            RD_LEFT:
            begin
                rd_a = nb_ll;
                rd_b = nb_l;
            end
            RD_RIGHT:
            begin
                rd_a = nb_rr;
                rd_b = nb_r;
            end
            default:
            begin
                rd_a = nb_l;
                rd_b = nb_r;
            end
        endcase
    end

    // phase store, valid bits and last-write bypass
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    phase_t             wr_data;
    logic [PHASE_W-1:0] ram_a;
    logic [PHASE_W-1:0] ram_b;

    ngea_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (MAX_CLIENTS)
    ) u_phase_ram (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    logic [MAX_CLIENTS-1:0] vld_reg;
    logic                   vld_a_reg;
    logic                   vld_b_reg;
    logic [IW-1:0]          rd_a_reg;
    logic [IW-1:0]          rd_b_reg;
    logic                   byp_valid_reg;
    logic [IW-1:0]          byp_addr_reg;
    phase_t                 byp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vld_a_reg     <= vld_reg[rd_a];
            vld_b_reg     <= vld_reg[rd_b];
            byp_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg     <= rd_a;
        rd_b_reg     <= rd_b;
        byp_addr_reg <= wr_addr;
        byp_data_reg <= wr_data;
    end

    phase_t ph_a;
    phase_t ph_b;

    always_comb
    begin
        priority if (byp_valid_reg && (byp_addr_reg == rd_a_reg))
            ph_a = byp_data_reg;
        else if (vld_a_reg)
            ph_a = phase_t'(ram_a);
        else
            ph_a = THINKING;

        priority if (byp_valid_reg && (byp_addr_reg == rd_b_reg))
            ph_b = byp_data_reg;
        else if (vld_b_reg)
            ph_b = phase_t'(ram_b);
        else
            ph_b = THINKING;
    end

    // grant test; the releasing client itself is known thinking
    logic [IW-1:0] target;
    logic          grant;

    always_comb
    begin
        unique case (cmd.eval_sel)
            EV_REQ:
            begin
                target = cidx_reg;
                grant  = (ph_a != EATING) && (ph_b != EATING);
            end
            EV_LEFT:
            begin
                target = nb_l;
                grant  = (ph_b == HUNGRY) && (ph_a != EATING);
            end
            EV_RIGHT:
            begin
                target = nb_r;
                grant  = (ph_b == HUNGRY) && (ph_a != EATING);
            end
            default:
            begin
                target = cidx_reg;
                grant  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.mark)
        begin
            wr_en   = 1'b1;
            wr_addr = IW'(client_index);
            wr_data = cmd.mark_phase;
        end
        else if (cmd.emit && !cmd.emit_bad && grant)
        begin
            wr_en   = 1'b1;
            wr_addr = target;
            wr_data = EATING;
        end
        else
        begin
            wr_en   = 1'b0;
            wr_addr = target;
            wr_data = EATING;
        end
    end

    // output register
    logic out_valid_reg;
    logic out_valid_next;

    assign out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            tested_client <= cmd.emit_bad ? idx_raw_reg : IDX_W'(target);
            granted       <= !cmd.emit_bad && grant;
            bad_index     <= cmd.emit_bad;
            last_result   <= cmd.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.in_bad   = BW'(client_index) >= BW'(ring_n);

endmodule

@@ design/neighbor_exclusive_grant_arbiter_unit.sv @@
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------------
// input     | in        | in_valid / in_stall   | func, client_index
// result    | out       | out_valid / out_stall | tested_client, granted, bad_index, last_result
// config    | in        | apb psel / penable    | paddr, pwdata, prdata (client_count)
//
// one item at a time: a request or a bad index loads its result from its test state after acceptance
// and returns to idle; a release loads its two results from the left and then the right test state
// each result is tested in its test state on the registered read of the phase ram
// reset: all clients thinking through per-entry valid bits, client count 5, no clearing pass
// a stalled result holds the block in its test state, re-reading the same phases;
// input is taken only while idle, even with a result still waiting
module neighbor_exclusive_grant_arbiter_unit #(
    parameter int MAX_CLIENTS = ngea_pkg::MAX_CLIENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ngea_pkg::ADDR_W-1:0] paddr,
    input  logic [ngea_pkg::DATA_W-1:0] pwdata,
    output logic [ngea_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // input items
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [ngea_pkg::IDX_W-1:0]  client_index,
    // result items
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ngea_pkg::IDX_W-1:0]  tested_client,
    output logic                        granted,
    output logic                        bad_index,
    output logic                        last_result
);

    import ngea_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: idle, request test, left test, right test, bad index report
    ngea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: count register, ring neighbours, phase ram, grant test, result register
    ngea_dp #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .client_index  (client_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tested_client (tested_client),
        .granted       (granted),
        .bad_index     (bad_index),
        .last_result   (last_result),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ngea_pkg::*;

    localparam int CLIENTS         = MAX_CLIENTS_DEF;
    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 9;
    // chance in a hundred that a side idles or stalls in a given cycle
    localparam int IDLE_PCT        = 11;
    localparam int RANDOM_PHASES   = 13;
    localparam int ITEMS_PER_PHASE = 150;
    // phase that runs with no idling on either side
    localparam int QUIET_PHASE     = 4;
    // every result is already out when the settle starts, so a short settle is plenty
    localparam int SETTLE_CYCLES   = 8;
    localparam int HANG_LIMIT      = 4000;

    localparam logic [ADDR_W-1:0] COUNT_ADDR = {REG_CLIENT_COUNT, 2'b00};

    // one test outcome as it should leave the result channel
    typedef struct packed {
        logic [IDX_W-1:0] client;
        logic             granted;
        logic             bad;
        logic             last;
    } grant_result_t;

    // tracks every client's phase and the results still owed by the block
    class grant_scoreboard;
        phase_t           client_phase [CLIENTS];
        logic [CNT_W-1:0] client_count;
        grant_result_t    awaited_grants [$];
        int               errors;

        function new();
            foreach (client_phase[i])
                client_phase[i] = THINKING;
            client_count = CLIENT_COUNT_RST;
            errors = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] value);
            client_count = value;
        endfunction

        // count clamped into 2 .. CLIENTS
        function int ring_size();
            int n;
            n = int'(client_count);
            if (n < 2)
                n = 2;
            if (n > CLIENTS)
                n = CLIENTS;
            return n;
        endfunction

        function int pending();
            return awaited_grants.size();
        endfunction

        // grant a hungry client whose neighbours are not eating
        function logic try_grant(int c, int n);
            int left;
            int right;
            left  = (c + n - 1) % n;
            right = (c + 1) % n;
            if (client_phase[left] != EATING && client_phase[c] == HUNGRY &&
                client_phase[right] != EATING)
            begin
                client_phase[c] = EATING;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_grant(int client, logic g, logic b, logic l);
            grant_result_t r;
            r.client  = IDX_W'(client);
            r.granted = g;
            r.bad     = b;
            r.last    = l;
            awaited_grants.push_back(r);
        endfunction

        function void note_input(logic f, logic [IDX_W-1:0] idx);
            int  n;
            int  c;
            int  left;
            int  right;
            logic g;
            n = ring_size();
            c = int'(idx);
            if (c >= n)
            begin
                push_grant(c, 1'b0, 1'b1, 1'b1);
                return;
            end
            if (f == FUNC_REQUEST)
            begin
                client_phase[c] = HUNGRY;
                g = try_grant(c, n);
                push_grant(c, g, 1'b0, 1'b1);
                return;
            end
            client_phase[c] = THINKING;
            left  = (c + n - 1) % n;
            right = (c + 1) % n;
            g = try_grant(left, n);
            push_grant(left, g, 1'b0, 1'b0);
            g = try_grant(right, n);
            push_grant(right, g, 1'b0, 1'b1);
        endfunction

        function void check_result(logic [IDX_W-1:0] client, logic g, logic b, logic l);
            grant_result_t exp_r;
            if (awaited_grants.size() == 0)
            begin
                $error("result with nothing awaited: tested_client %0d", client);
                errors++;
                return;
            end
            exp_r = awaited_grants.pop_front();
            if (client !== exp_r.client)
            begin
                $error("tested_client: expected %0d, actual %0d", exp_r.client, client);
                errors++;
            end
            if (g !== exp_r.granted)
            begin
                $error("granted: expected %0d, actual %0d", exp_r.granted, g);
                errors++;
            end
            if (b !== exp_r.bad)
            begin
                $error("bad_index: expected %0d, actual %0d", exp_r.bad, b);
                errors++;
            end
            if (l !== exp_r.last)
            begin
                $error("last_result: expected %0d, actual %0d", exp_r.last, l);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              func;
    logic [IDX_W-1:0]  client_index;
    logic              out_valid;
    logic              out_stall;
    logic [IDX_W-1:0]  tested_client;
    logic              granted;
    logic              bad_index;
    logic              last_result;

    // set while the no-idling stretch runs
    logic              quiet = 1'b0;
    int                hang_cycles = 0;

    grant_scoreboard sb = new();

    neighbor_exclusive_grant_arbiter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .client_index  (client_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tested_client (tested_client),
        .granted       (granted),
        .bad_index     (bad_index),
        .last_result   (last_result)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // result side back-pressure, off during the quiet stretch
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // every result taken at this edge is held against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(tested_client, granted, bad_index, last_result);
    end

    // count cycles in which neither channel nor the config port moves
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
    end

    initial
    begin
        while (hang_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // one item: random idle gap, then hold until the block takes it
    task automatic send_item(input logic f, input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        client_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(f, idx);
    endtask

    // stop sending and let every awaited result come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // apb write of the client count followed by a read back
    task automatic set_client_count(input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_count(value);
        // straight into the setup cycle of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CNT_W-1:0] !== value)
        begin
            $error("client_count: expected %0d, actual %0d", value, prdata[CNT_W-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly indices on the ring in use, some anywhere in the field
    task automatic send_random_item();
        logic [IDX_W-1:0] idx;
        logic             f;
        if ($urandom_range(0, 99) < 85)
            idx = IDX_W'($urandom_range(0, sb.ring_size() - 1));
        else
            idx = IDX_W'($urandom_range(0, CLIENTS - 1));
        f = 1'($urandom_range(0, 1));
        send_item(f, idx);
    endtask

    initial
    begin
        int preset_counts [7];
        logic [CNT_W-1:0] cnt;

        preset_counts = '{8, 2, 15, 0, 3, 9, 1};

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        func         = FUNC_REQUEST;
        client_index = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ring of five out of reset
        send_item(FUNC_REQUEST, 3'd0);
        send_item(FUNC_REQUEST, 3'd1);
        send_item(FUNC_REQUEST, 3'd4);
        // release wakes both neighbours
        send_item(FUNC_RELEASE, 3'd0);
        // indices off the ring, request and release, then a request and a release on it
        send_item(FUNC_REQUEST, 3'd7);
        send_item(FUNC_RELEASE, 3'd5);
        send_item(FUNC_REQUEST, 3'd2);
        send_item(FUNC_RELEASE, 3'd1);
        // an eating client asks again
        send_item(FUNC_REQUEST, 3'd2);
        // a thinking client releases
        send_item(FUNC_RELEASE, 3'd3);
        wait_idle();

        // two clients: the same neighbour is tested twice
        set_client_count(4'd2);
        send_item(FUNC_REQUEST, 3'd0);
        send_item(FUNC_REQUEST, 3'd1);
        send_item(FUNC_RELEASE, 3'd0);
        send_item(FUNC_REQUEST, 3'd2);
        wait_idle();

        // count below the minimum is taken as two
        set_client_count(4'd0);
        send_item(FUNC_RELEASE, 3'd1);
        send_item(FUNC_REQUEST, 3'd3);
        wait_idle();

        // counts above the maximum are taken as the full ring, one below the minimum as two
        set_client_count(4'd15);
        send_item(FUNC_REQUEST, 3'd7);
        send_item(FUNC_REQUEST, 3'd0);
        send_item(FUNC_RELEASE, 3'd7);
        send_item(FUNC_RELEASE, 3'd0);
        wait_idle();
        set_client_count(4'd9);
        send_item(FUNC_REQUEST, 3'd6);
        send_item(FUNC_RELEASE, 3'd5);
        wait_idle();
        set_client_count(4'd1);
        send_item(FUNC_REQUEST, 3'd1);
        send_item(FUNC_RELEASE, 3'd1);
        wait_idle();

        // random phases, each under its own ring size
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 7)
                cnt = CNT_W'(preset_counts[p]);
            else
                cnt = CNT_W'($urandom_range(0, 15));
            quiet <= (p == QUIET_PHASE);
            set_client_count(cnt);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_item();
            wait_idle();
        end
        quiet <= 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
